// ===== src/mdw_pkg.sv =====
// ----------------------------------------------------------------------------
// mdw_pkg
// Types, codes and grid helpers shared by the maze walker modules.
// ----------------------------------------------------------------------------
package mdw_pkg;

  localparam int MAX_SIDE = 16;
  localparam int SIDE_W   = 4;
  localparam int CELL_W   = 2 * SIDE_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int DEPTH_W  = 9;
  localparam int STEP_W   = 16;
  localparam int GSZ_W    = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } mdw_act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 3'd0,
    CFG_START_ROW = 3'd1,
    CFG_START_COL = 3'd2,
    CFG_GOAL_ROW  = 3'd3,
    CFG_GOAL_COL  = 3'd4
  } mdw_cfg_idx_t;

  localparam logic [1:0] CELL_WALL = 2'd0;
  localparam logic [1:0] CELL_OPEN = 2'd1;
  localparam logic [1:0] CELL_SEEN = 2'd2;
  localparam logic [1:0] CELL_HERE = 2'd3;

  localparam logic [2:0] MV_NONE = 3'd0;
  localparam logic [2:0] MV_BACK = 3'd5;

  localparam logic [1:0] RS_RUN    = 2'd0;
  localparam logic [1:0] RS_GOAL   = 2'd1;
  localparam logic [1:0] RS_NOPATH = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_INIT,
    S_CHECK,
    S_PROBE,
    S_DECIDE,
    S_PLACE_MV,
    S_PLACE_BK
  } mdw_state_t;

  typedef enum logic [1:0] {
    FIN_LOAD,
    FIN_POS,
    FIN_GOAL,
    FIN_STUCK
  } mdw_fin_t;

  typedef struct packed {
    mdw_act_t          action;
    logic [SIDE_W-1:0] cell_row;
    logic [SIDE_W-1:0] cell_col;
    logic              cell_open;
  } mdw_in_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  pos_row;
    logic [SIDE_W-1:0]  pos_col;
    logic [2:0]         move_kind;
    logic [1:0]         status;
    logic [DEPTH_W-1:0] path_depth;
    logic [STEP_W-1:0]  attempts;
  } mdw_out_t;

  typedef struct packed {
    logic     latch;
    logic     load_wr;
    logic     init;
    logic     step_begin;
    logic     probe;
    logic [1:0] dir;
    logic     push_mark;
    logic     back_mark;
    logic     place_move;
    logic     place_pop;
    logic     finish;
    mdw_fin_t fin;
  } mdw_cmd_t;

  typedef struct packed {
    logic at_goal;
    logic any_ok;
    logic stack_empty;
  } mdw_sts_t;

  function automatic logic [CELL_W-1:0] nb_addr(input logic [SIDE_W-1:0] r,
                                                input logic [SIDE_W-1:0] c,
                                                input logic [1:0]        d);
    logic [CELL_W-1:0] a;
    unique case (d)
      DIR_UP:    a = {r - 4'd1, c};
      DIR_RIGHT: a = {r, c + 4'd1};
      DIR_DOWN:  a = {r + 4'd1, c};
      default:   a = {r, c - 4'd1};
    endcase
    return a;
  endfunction

  function automatic logic nb_inside(input logic [SIDE_W-1:0] r,
                                     input logic [SIDE_W-1:0] c,
                                     input logic [1:0]        d,
                                     input logic [GSZ_W-1:0]  side);
    logic ok;
    unique case (d)
      DIR_UP:    ok = (r != 4'd0);
      DIR_RIGHT: ok = (({1'b0, c} + 5'd1) < side);
      DIR_DOWN:  ok = (({1'b0, r} + 5'd1) < side);
      default:   ok = (c != 4'd0);
    endcase
    return ok;
  endfunction

endpackage

// ===== src/mdw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdw_ctrl
// Sequencer for the maze walker: dispatches items and drives the datapath.
// ----------------------------------------------------------------------------
module mdw_ctrl import mdw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mdw_act_t in_action,
  input  mdw_sts_t sts,
  output mdw_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  mdw_state_t state_r, state_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    cmd       = '0;
    cmd.fin   = FIN_LOAD;
    cmd.dir   = dir_r;
    unique case (state_r)
      S_IDLE: begin
        dir_nxt = 2'd0;
        if (start) begin
          cmd.latch = 1'b1;
          unique case (in_action)
            ACT_START: state_nxt = S_INIT;
            ACT_STEP:  state_nxt = S_CHECK;
            default:   state_nxt = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.finish  = 1'b1;
        cmd.fin     = FIN_LOAD;
        state_nxt   = S_IDLE;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        cmd.finish = 1'b1;
        cmd.fin    = FIN_POS;
        state_nxt  = S_IDLE;
      end
      S_CHECK: begin
        if (sts.at_goal) begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_GOAL;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step_begin = 1'b1;
          cmd.probe      = 1'b1;
          dir_nxt        = dir_r + 2'd1;
          state_nxt      = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        dir_nxt   = dir_r + 2'd1;
        if (dir_r == DIR_LEFT) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts.any_ok) begin
          cmd.push_mark = 1'b1;
          state_nxt     = S_PLACE_MV;
        end else if (!sts.stack_empty) begin
          cmd.back_mark = 1'b1;
          state_nxt     = S_PLACE_BK;
        end else begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_STUCK;
          state_nxt  = S_IDLE;
        end
      end
      S_PLACE_MV: begin
        cmd.place_move = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin        = FIN_POS;
        state_nxt      = S_IDLE;
      end
      S_PLACE_BK: begin
        cmd.place_pop = 1'b1;
        cmd.finish    = 1'b1;
        cmd.fin       = FIN_POS;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.finish;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while an item is still in work");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

endmodule

// ===== src/mdw_datapath.sv =====
// ----------------------------------------------------------------------------
// mdw_datapath
// Maze map, path stack, walker registers and result register.
// ----------------------------------------------------------------------------
module mdw_datapath import mdw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdw_in_t              in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GSZ_W-1:0]     cfg_wdata,
  input  mdw_cmd_t             cmd,
  output mdw_sts_t             sts,
  output mdw_out_t             out_item
);

  logic [1:0]        map_mem [CELLS];
  logic [CELL_W-1:0] stk_mem [CELLS];

  mdw_in_t           in_q_r;
  logic [GSZ_W-1:0]  grid_size_r;
  logic [SIDE_W-1:0] start_row_r, start_col_r, goal_row_r, goal_col_r;

  logic [SIDE_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [DEPTH_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;

  logic       pv_r, inb_r;
  logic [1:0] pd_r, mv_dir_r;
  logic [3:0] ok_r, ok_all;
  logic [1:0] map_rdata_r;
  logic [CELL_W-1:0] stk_rdata_r;

  logic [GSZ_W-1:0]  side;
  logic [1:0]        pick;
  logic              map_we;
  logic [CELL_W-1:0] map_waddr, map_raddr, cur_addr, mv_addr;
  logic [1:0]        map_wdata;
  logic              goal_nxt;
  mdw_out_t          out_r, out_nxt;

  always_comb begin
    priority if (grid_size_r > GSZ_W'(MAX_SIDE)) side = GSZ_W'(MAX_SIDE);
    else if (grid_size_r < 5'd2)                 side = 5'd2;
    else                                         side = grid_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GSZ_W'(MAX_SIDE);
      start_row_r <= 4'd0;
      start_col_r <= 4'd0;
      goal_row_r  <= 4'd15;
      goal_col_r  <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE: grid_size_r <= cfg_wdata;
        CFG_START_ROW: start_row_r <= cfg_wdata[SIDE_W-1:0];
        CFG_START_COL: start_col_r <= cfg_wdata[SIDE_W-1:0];
        CFG_GOAL_ROW:  goal_row_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_GOAL_COL:  goal_col_r  <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) in_q_r <= in_item;
  end

  assign cur_addr  = {row_r, col_r};
  assign mv_addr   = nb_addr(row_r, col_r, mv_dir_r);
  assign map_raddr = nb_addr(row_r, col_r, cmd.dir);

  // probe results; the last direction arrives in the decide cycle
  assign ok_all = ok_r | ({3'b000, pv_r & inb_r & map_rdata_r[0]} << pd_r);

  always_comb begin
    priority if (ok_all[0]) pick = DIR_UP;
    else if (ok_all[1])     pick = DIR_RIGHT;
    else if (ok_all[2])     pick = DIR_DOWN;
    else                    pick = DIR_LEFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ok_r <= 4'd0;
    end else begin
      pv_r <= cmd.probe;
      if (cmd.step_begin) ok_r <= 4'd0;
      else if (pv_r)      ok_r <= ok_all;
    end
  end

  always_ff @(posedge clk) begin
    inb_r <= nb_inside(row_r, col_r, cmd.dir, side);
    pd_r  <= cmd.dir;
    if (cmd.push_mark) mv_dir_r <= pick;
  end

  always_comb begin
    map_we    = 1'b1;
    map_waddr = cur_addr;
    map_wdata = CELL_SEEN;
    priority if (cmd.load_wr) begin
      map_we    = (in_q_r.action == ACT_LOAD);
      map_waddr = {in_q_r.cell_row, in_q_r.cell_col};
      map_wdata = in_q_r.cell_open ? CELL_OPEN : CELL_WALL;
    end else if (cmd.push_mark || cmd.back_mark) begin
      map_waddr = cur_addr;
      map_wdata = CELL_SEEN;
    end else if (cmd.place_move) begin
      map_waddr = mv_addr;
      map_wdata = CELL_HERE;
    end else if (cmd.place_pop) begin
      map_waddr = stk_rdata_r;
      map_wdata = CELL_HERE;
    end else begin
      map_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_mark && !count_r[DEPTH_W-1]) stk_mem[count_r[CELL_W-1:0]] <= cur_addr;
    stk_rdata_r <= stk_mem[CELL_W'(count_r - 9'd1)];
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    count_nxt = count_r;
    steps_nxt = steps_r;
    if (cmd.init) begin
      row_nxt   = ({1'b0, start_row_r} < side) ? start_row_r : SIDE_W'(side - 5'd1);
      col_nxt   = ({1'b0, start_col_r} < side) ? start_col_r : SIDE_W'(side - 5'd1);
      count_nxt = '0;
      steps_nxt = '0;
    end
    if (cmd.step_begin && (steps_r != {STEP_W{1'b1}})) steps_nxt = steps_r + 16'd1;
    if (cmd.push_mark && !count_r[DEPTH_W-1]) count_nxt = count_r + 9'd1;
    if (cmd.place_move) begin
      row_nxt = mv_addr[CELL_W-1:SIDE_W];
      col_nxt = mv_addr[SIDE_W-1:0];
    end
    if (cmd.place_pop) begin
      row_nxt   = stk_rdata_r[CELL_W-1:SIDE_W];
      col_nxt   = stk_rdata_r[SIDE_W-1:0];
      count_nxt = count_r - 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      count_r <= '0;
      steps_r <= '0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      count_r <= count_nxt;
      steps_r <= steps_nxt;
    end
  end

  assign goal_nxt = (row_nxt == goal_row_r) && (col_nxt == goal_col_r);

  always_comb begin
    out_nxt.pos_row    = row_nxt;
    out_nxt.pos_col    = col_nxt;
    out_nxt.path_depth = count_nxt;
    out_nxt.attempts   = steps_nxt;
    priority if (cmd.place_move) out_nxt.move_kind = {1'b0, mv_dir_r} + 3'd1;
    else if (cmd.place_pop)      out_nxt.move_kind = MV_BACK;
    else                         out_nxt.move_kind = MV_NONE;
    unique case (cmd.fin)
      FIN_POS:   out_nxt.status = goal_nxt ? RS_GOAL : RS_RUN;
      FIN_GOAL:  out_nxt.status = RS_GOAL;
      FIN_STUCK: out_nxt.status = RS_NOPATH;
      default:   out_nxt.status = RS_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_item        = out_r;
  assign sts.at_goal     = (row_r == goal_row_r) && (col_r == goal_col_r);
  assign sts.any_ok      = |ok_all;
  assign sts.stack_empty = (count_r == '0);

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_W'(CELLS))
    else $error("path stack depth beyond cell count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_pop |-> (count_r != '0))
    else $error("pop from an empty path stack");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_mark && !count_r[DEPTH_W-1]) |=> (count_r == $past(count_r) + 9'd1))
    else $error("push did not grow the path stack");

endmodule

// ===== src/maze_depth_first_walker_core.sv =====
// ----------------------------------------------------------------------------
// maze_depth_first_walker_core
// Depth-first maze walker with backtracking over a 16 x 16 cell map.
//
// Input items are offered on in_item with start; one is taken at a clock
// edge where start is high and busy is low. Actions: load one cell, start
// the walk, take one step. Each item yields exactly one result on out_item,
// flagged by out_valid for a single cycle; the receiver cannot stall it.
// Configuration (grid size, start, goal) is written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while the block is
// idle, which the block does not enforce. A step at the goal ends after
// the goal check, a step with no path after the four probes and decide,
// a move or backtrack after two cell writes: the map has one read port,
// so the neighbors are read one per cycle, then two cells are written.
// busy drops in the cycle the result is shown, so the next item can be
// accepted then. Reset clears the walker, stack depth, step count and
// loads the default configuration; the cell map and stack are not cleared
// and must be loaded before a walk.
// ----------------------------------------------------------------------------
module maze_depth_first_walker_core import mdw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mdw_in_t              in_item,
  output logic                 out_valid,
  output mdw_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GSZ_W-1:0]     cfg_wdata
);

  mdw_cmd_t cmd;
  mdw_sts_t sts;

  mdw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mdw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/maze_depth_first_walker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maze_depth_first_walker_core_tb
// Self-checking bench for the depth-first maze walker. It loads mazes of many
// sizes, places the walker and steps it. Counted stuck steps are exercised
// on a sealed start cell. Every report is checked against a walk predictor
// that follows each accepted item.
// ----------------------------------------------------------------------------
module maze_depth_first_walker_core_tb;
  import mdw_pkg::*;

  localparam logic [2:0] MV_UP    = 3'd1;
  localparam logic [2:0] MV_RIGHT = 3'd2;
  localparam logic [2:0] MV_DOWN  = 3'd3;
  localparam logic [2:0] MV_LEFT  = 3'd4;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 400;
  localparam int STUCK_STEPS    = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  class walker_scoreboard;
    logic [1:0]        cell_st [CELLS];
    logic [CELL_W-1:0] trail [CELLS];
    int unsigned       row, col, depth, attempts;
    logic [GSZ_W-1:0]  grid_reg;
    int unsigned       start_r, start_c, goal_r, goal_c;
    mdw_out_t          expected_reports [$];
    int                errors;

    function new();
      foreach (cell_st[i]) cell_st[i] = CELL_WALL;
      foreach (trail[i]) trail[i] = '0;
      row = 0;
      col = 0;
      depth = 0;
      attempts = 0;
      grid_reg = GSZ_W'(MAX_SIDE);
      start_r = 0;
      start_c = 0;
      goal_r = MAX_SIDE - 1;
      goal_c = MAX_SIDE - 1;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GSZ_W-1:0] value);
      case (idx)
        CFG_GRID_SIZE: grid_reg = value;
        CFG_START_ROW: start_r = value[SIDE_W-1:0];
        CFG_START_COL: start_c = value[SIDE_W-1:0];
        CFG_GOAL_ROW:  goal_r = value[SIDE_W-1:0];
        CFG_GOAL_COL:  goal_c = value[SIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned side_of(logic [GSZ_W-1:0] g);
      if (g > MAX_SIDE) return MAX_SIDE;
      if (g < 2) return 2;
      return g;
    endfunction

    function bit open_at(int unsigned r, int unsigned c);
      logic [1:0] v;
      v = cell_st[r * MAX_SIDE + c];
      return v != CELL_WALL && v != CELL_SEEN;
    endfunction

    function bit at_goal();
      return row == goal_r && col == goal_c;
    endfunction

    function void advance_walk(mdw_in_t it);
      int unsigned side, nr, nc, back;
      logic [2:0]  move;
      logic [1:0]  st;
      mdw_out_t    rpt;
      side = side_of(grid_reg);
      move = MV_NONE;
      st = RS_RUN;
      nr = row;
      nc = col;
      case (it.action)
        ACT_LOAD: cell_st[{it.cell_row, it.cell_col}] = it.cell_open ? CELL_OPEN : CELL_WALL;
        ACT_START: begin
          row = (start_r < side) ? start_r : side - 1;
          col = (start_c < side) ? start_c : side - 1;
          depth = 0;
          attempts = 0;
          st = at_goal() ? RS_GOAL : RS_RUN;
        end
        ACT_STEP: begin
          if (at_goal()) begin
            st = RS_GOAL;
          end else begin
            if (attempts < (1 << STEP_W) - 1) attempts++;
            if (row > 0 && open_at(row - 1, col)) begin
              nr = row - 1;
              move = MV_UP;
            end else if (col + 1 < side && open_at(row, col + 1)) begin
              nc = col + 1;
              move = MV_RIGHT;
            end else if (row + 1 < side && open_at(row + 1, col)) begin
              nr = row + 1;
              move = MV_DOWN;
            end else if (col > 0 && open_at(row, col - 1)) begin
              nc = col - 1;
              move = MV_LEFT;
            end
            if (move != MV_NONE) begin
              if (depth < CELLS) begin
                trail[depth] = CELL_W'(row * MAX_SIDE + col);
                depth++;
              end
              cell_st[row * MAX_SIDE + col] = CELL_SEEN;
              cell_st[nr * MAX_SIDE + nc] = CELL_HERE;
              row = nr;
              col = nc;
              st = at_goal() ? RS_GOAL : RS_RUN;
            end else if (depth > 0) begin
              cell_st[row * MAX_SIDE + col] = CELL_SEEN;
              depth--;
              back = trail[depth];
              row = back / MAX_SIDE;
              col = back % MAX_SIDE;
              cell_st[back] = CELL_HERE;
              move = MV_BACK;
              st = at_goal() ? RS_GOAL : RS_RUN;
            end else begin
              st = RS_NOPATH;
            end
          end
        end
        default: ;
      endcase
      rpt.pos_row = SIDE_W'(row);
      rpt.pos_col = SIDE_W'(col);
      rpt.move_kind = move;
      rpt.status = st;
      rpt.path_depth = DEPTH_W'(depth);
      rpt.attempts = STEP_W'(attempts);
      expected_reports.push_back(rpt);
    endfunction

    function void check_field(string name, logic [STEP_W-1:0] want, logic [STEP_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(mdw_out_t got);
      mdw_out_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with nothing outstanding, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("pos_row", STEP_W'(want.pos_row), STEP_W'(got.pos_row));
      check_field("pos_col", STEP_W'(want.pos_col), STEP_W'(got.pos_col));
      check_field("move_kind", STEP_W'(want.move_kind), STEP_W'(got.move_kind));
      check_field("status", STEP_W'(want.status), STEP_W'(got.status));
      check_field("path_depth", STEP_W'(want.path_depth), STEP_W'(got.path_depth));
      check_field("attempts", want.attempts, got.attempts);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  mdw_in_t              in_item = '0;
  logic                 out_valid;
  mdw_out_t             out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GSZ_W-1:0]     cfg_wdata = '0;

  bit cell_loaded [CELLS];
  bit no_idle = 1'b0;
  int items_sent = 0;
  int quiet = 0;
  walker_scoreboard sb;

  maze_depth_first_walker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) sb.check_report(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAIL maze_depth_first_walker_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [SIDE_W-1:0] pick_coord(int unsigned side);
    if ($urandom_range(0, 7) == 0) return SIDE_W'($urandom_range(0, MAX_SIDE - 1));
    return SIDE_W'($urandom_range(0, side - 1));
  endfunction

  task automatic send_item(mdw_act_t act, logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c,
                           logic o);
    mdw_in_t     it;
    int unsigned k, gap;
    it.action = act;
    it.cell_row = r;
    it.cell_col = c;
    it.cell_open = o;
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.advance_walk(it);
    if (act != ACT_NONE) items_sent++;
    k = $urandom_range(0, 99);
    if (no_idle || k < 55) gap = 0;
    else if (k < 85) gap = $urandom_range(1, 3);
    else if (k < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_cell(logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c, logic o);
    send_item(ACT_LOAD, r, c, o);
    cell_loaded[{r, c}] = 1'b1;
  endtask

  task automatic take_step();
    send_item(ACT_STEP, SIDE_W'($urandom), SIDE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic start_walk();
    send_item(ACT_START, SIDE_W'($urandom), SIDE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    if (start) start <= 1'b0;
    while (sb.expected_reports.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GSZ_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_walk(logic [GSZ_W-1:0] gsz, logic [SIDE_W-1:0] sr,
                          logic [SIDE_W-1:0] sc, logic [SIDE_W-1:0] gr,
                          logic [SIDE_W-1:0] gc);
    wait_drained();
    write_reg(CFG_GRID_SIZE, gsz);
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_GOAL_ROW, gr);
    write_reg(CFG_GOAL_COL, gc);
    cfg_we <= 1'b0;
  endtask

  task automatic random_walk(logic [GSZ_W-1:0] gsz);
    int unsigned side, n, k;
    bit          fresh;
    side = sb.side_of(gsz);
    set_walk(gsz, pick_coord(side), pick_coord(side), pick_coord(side), pick_coord(side));
    no_idle = ($urandom_range(0, 3) == 0);
    fresh = (side <= 8) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
    for (int unsigned rr = 0; rr < side; rr++) begin
      for (int unsigned cc = 0; cc < side; cc++) begin
        if (fresh || !cell_loaded[rr * MAX_SIDE + cc])
          load_cell(SIDE_W'(rr), SIDE_W'(cc), $urandom_range(0, 9) < 7);
      end
    end
    repeat ($urandom_range(0, 3))
      load_cell(SIDE_W'($urandom), SIDE_W'($urandom), 1'($urandom_range(0, 1)));
    start_walk();
    n = $urandom_range(side, 2 * side * side + 4);
    if (n > 160) n = $urandom_range(100, 160);
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 88) take_step();
      else if (k < 93)
        load_cell(SIDE_W'($urandom), SIDE_W'($urandom), 1'($urandom_range(0, 1)));
      else if (k < 96)
        send_item(ACT_NONE, SIDE_W'($urandom), SIDE_W'($urandom), 1'($urandom_range(0, 1)));
      else start_walk();
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  initial begin
    int                target;
    int unsigned       k;
    logic [GSZ_W-1:0]  gsz;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = int'(CFG_GOAL_COL) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), GSZ_W'($urandom_range(0, 31)));

    // clamp start into a side-2 maze, walk up then left onto the goal
    set_walk(GSZ_W'(1), 4'd15, 4'd15, 4'd0, 4'd0);
    send_item(ACT_NONE, 4'd15, 4'd15, 1'b1);
    load_cell(4'd0, 4'd0, 1'b1);
    load_cell(4'd0, 4'd1, 1'b1);
    load_cell(4'd1, 4'd0, 1'b0);
    load_cell(4'd1, 4'd1, 1'b1);
    load_cell(4'd15, 4'd15, 1'b1);
    load_cell(4'd15, 4'd0, 1'b0);
    start_walk();
    repeat (3) take_step();

    // move down, backtrack, get stuck, restart over the visited marks
    set_walk(GSZ_W'(0), 4'd0, 4'd0, 4'd15, 4'd0);
    load_cell(4'd0, 4'd0, 1'b1);
    load_cell(4'd0, 4'd1, 1'b0);
    load_cell(4'd1, 4'd0, 1'b1);
    load_cell(4'd1, 4'd1, 1'b0);
    start_walk();
    repeat (4) take_step();
    start_walk();
    take_step();

    target = items_sent + RANDOM_ITEMS;
    for (int w = 0; items_sent < target; w++) begin
      k = $urandom_range(0, 99);
      if (w == 0) gsz = '1;
      else if (k < 60) gsz = GSZ_W'($urandom_range(2, 5));
      else if (k < 80) gsz = GSZ_W'($urandom_range(6, 10));
      else if (k < 92) gsz = GSZ_W'($urandom_range(11, MAX_SIDE));
      else if (k < 96) gsz = GSZ_W'($urandom_range(0, 1));
      else gsz = GSZ_W'($urandom_range(MAX_SIDE + 1, 31));
      random_walk(gsz);
    end

    // sealed start cell: every step is stuck and counted
    set_walk(GSZ_W'(2), 4'd0, 4'd0, 4'd1, 4'd1);
    no_idle = 1'b0;
    load_cell(4'd0, 4'd0, 1'b1);
    load_cell(4'd0, 4'd1, 1'b0);
    load_cell(4'd1, 4'd0, 1'b0);
    load_cell(4'd1, 4'd1, 1'b1);
    start_walk();
    no_idle = 1'b1;
    repeat (STUCK_STEPS) take_step();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0)
      $display("PASS maze_depth_first_walker_core");
    else
      $display("FAIL maze_depth_first_walker_core");
    $finish;
  end

endmodule
